FILE: design/e2r_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the Euler-to-DCM unit.
package e2r_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int FRAC_BITS_DEF     = 14;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int IN_W              = 16;
    localparam int OUT_W             = 16;
    localparam int TURN_W            = 32;
    localparam int CW                = 34;
    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

    typedef logic signed [CW-1:0] cval_t;

    typedef struct packed {
        cval_t c;
        cval_t s;
    } sc_t;

    function automatic logic [TURN_W-1:0] atan_turn(input int idx);
        logic [TURN_W-1:0] t;
        begin
            unique case (idx)
                0: t = 32'd536870912;   1: t = 32'd316933406;
                2: t = 32'd167458907;   3: t = 32'd85004756;
                4: t = 32'd42667331;    5: t = 32'd21354465;
                6: t = 32'd10679838;    7: t = 32'd5340245;
                8: t = 32'd2670163;     9: t = 32'd1335087;
                10: t = 32'd667544;     11: t = 32'd333772;
                12: t = 32'd166886;     13: t = 32'd83443;
                14: t = 32'd41722;      15: t = 32'd20861;
                16: t = 32'd10430;      17: t = 32'd5215;
                18: t = 32'd2608;       19: t = 32'd1304;
                20: t = 32'd652;        21: t = 32'd326;
                22: t = 32'd163;        23: t = 32'd81;
                24: t = 32'd41;         25: t = 32'd20;
                26: t = 32'd10;         27: t = 32'd5;
                28: t = 32'd3;          29: t = 32'd1;
                30: t = 32'd1;
                default: t = 32'd0;
            endcase
            return t;
        end
    endfunction

endpackage

FILE: design/e2r_cordic_lane.sv
// Pipelined rotation-mode CORDIC lane: binary angle in, quadrant-mapped cosine and sine out.
module e2r_cordic_lane #(
    parameter int ANGLE_BITS    = e2r_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = e2r_pkg::CORDIC_STAGES_DEF
) (
    input  logic                     aclk,
    input  logic [e2r_pkg::IN_W-1:0] angle,
    input  logic                     en,
    output e2r_pkg::sc_t             sc
);

    localparam int NS = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int TW = e2r_pkg::TURN_W;
    localparam logic [TW-1:0] AMASK = (ANGLE_BITS >= TW) ? '1
                                      : TW'((64'd1 << ANGLE_BITS) - 64'd1);

    e2r_pkg::cval_t    x_reg [0:NS];
    e2r_pkg::cval_t    y_reg [0:NS];
    logic signed [TW:0] z_reg [0:NS];
    logic [1:0]         q_reg [0:NS];

    logic [TW-1:0] a_raw;
    logic [TW-1:0] a_turn;
    logic [1:0]    q_next;
    logic [TW-1:0] d_next;

    always_comb begin
        a_raw  = TW'(angle) & AMASK;
        a_turn = a_raw << (TW - ANGLE_BITS);
        q_next = 2'((a_turn + 32'h2000_0000) >> 30);
        d_next = a_turn - {q_next, 30'd0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= e2r_pkg::CORDIC_X0;
            y_reg[0] <= '0;
            z_reg[0] <= {d_next[TW-1], d_next};
            q_reg[0] <= q_next;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[i][TW]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - $signed({1'b0, e2r_pkg::atan_turn(i)});
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + $signed({1'b0, e2r_pkg::atan_turn(i)});
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    always_comb begin
        unique case (q_reg[NS])
            2'd0: begin sc.c = x_reg[NS];  sc.s = y_reg[NS];  end
            2'd1: begin sc.c = -y_reg[NS]; sc.s = x_reg[NS];  end
            2'd2: begin sc.c = -x_reg[NS]; sc.s = -y_reg[NS]; end
            default: begin sc.c = y_reg[NS]; sc.s = -x_reg[NS]; end
        endcase
    end

endmodule

FILE: design/e2r_merge.sv
// Merge stage: forms the nine matrix entries from three sine/cosine pairs, rounds and saturates.
module e2r_merge #(
    parameter int FRAC_BITS = e2r_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             en,
    input  e2r_pkg::sc_t                     rl,
    input  e2r_pkg::sc_t                     pt,
    input  e2r_pkg::sc_t                     hd,
    output logic signed [e2r_pkg::OUT_W-1:0] ent [0:8]
);

    localparam int PW = 68;
    localparam int SH = 60 - FRAC_BITS;
    typedef logic signed [PW-1:0] p_t;

    // stage A: pair products, carry heading sine/cosine forward
    p_t spsr_a_reg, crsp_a_reg, cpch_a_reg, crsh_a_reg, shsr_a_reg, cpsh_a_reg;
    p_t crch_a_reg, srch_a_reg, sp_a_reg, srcp_a_reg, crcp_a_reg;
    e2r_pkg::cval_t ch_a_reg, sh_a_reg;
    // stage B: rounded Q30 triple-product factors times heading
    p_t s0_b_reg [0:8];
    p_t t1_reg, t2_reg, t4_reg, t5_reg;
    p_t sum_c_reg [0:8];

    // rounded Q30 factor; magnitude stays within one lane value
    function automatic e2r_pkg::cval_t q30r(input p_t v);
        p_t r;
        begin
            r = (v + (p_t'(1) <<< 29)) >>> 30;
            return r[e2r_pkg::CW-1:0];
        end
    endfunction

    function automatic logic signed [e2r_pkg::OUT_W-1:0] fin(input p_t v);
        p_t r;
        p_t one;
        begin
            r   = (v + (p_t'(1) <<< (SH - 1))) >>> SH;
            one = p_t'(1) <<< FRAC_BITS;
            if (r > one) r = one;
            if (r < -one) r = -one;
            return r[e2r_pkg::OUT_W-1:0];
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            spsr_a_reg <= PW'(pt.s) * PW'(rl.s);
            crsp_a_reg <= PW'(rl.c) * PW'(pt.s);
            cpch_a_reg <= PW'(pt.c) * PW'(hd.c);
            crsh_a_reg <= PW'(rl.c) * PW'(hd.s);
            shsr_a_reg <= PW'(hd.s) * PW'(rl.s);
            cpsh_a_reg <= PW'(pt.c) * PW'(hd.s);
            crch_a_reg <= PW'(rl.c) * PW'(hd.c);
            srch_a_reg <= PW'(rl.s) * PW'(hd.c);
            sp_a_reg   <= -(PW'(pt.s) <<< 30);
            srcp_a_reg <= PW'(rl.s) * PW'(pt.c);
            crcp_a_reg <= PW'(rl.c) * PW'(pt.c);
            ch_a_reg   <= hd.c;
            sh_a_reg   <= hd.s;

            t1_reg <= PW'(q30r(spsr_a_reg)) * PW'(ch_a_reg);
            t2_reg <= PW'(q30r(crsp_a_reg)) * PW'(ch_a_reg);
            t4_reg <= PW'(q30r(spsr_a_reg)) * PW'(sh_a_reg);
            t5_reg <= PW'(q30r(crsp_a_reg)) * PW'(sh_a_reg);
            s0_b_reg[0] <= cpch_a_reg;
            s0_b_reg[1] <= -crsh_a_reg;
            s0_b_reg[2] <= shsr_a_reg;
            s0_b_reg[3] <= cpsh_a_reg;
            s0_b_reg[4] <= crch_a_reg;
            s0_b_reg[5] <= -srch_a_reg;
            s0_b_reg[6] <= sp_a_reg;
            s0_b_reg[7] <= srcp_a_reg;
            s0_b_reg[8] <= crcp_a_reg;

            sum_c_reg[0] <= s0_b_reg[0];
            sum_c_reg[1] <= t1_reg + s0_b_reg[1];
            sum_c_reg[2] <= t2_reg + s0_b_reg[2];
            sum_c_reg[3] <= s0_b_reg[3];
            sum_c_reg[4] <= t4_reg + s0_b_reg[4];
            sum_c_reg[5] <= t5_reg + s0_b_reg[5];
            sum_c_reg[6] <= s0_b_reg[6];
            sum_c_reg[7] <= s0_b_reg[7];
            sum_c_reg[8] <= s0_b_reg[8];
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) ent[k] = fin(sum_c_reg[k]);
    end

endmodule

FILE: design/euler_to_rotation_matrix_unit.sv
// Top level: Euler angles (heading-pitch-roll) to direction cosine matrix.
// Throughput: one request per cycle while the output is not stalled.
// Three CORDIC lanes and the product stages run as one pipeline.
// The pipeline advances whenever its last stage is empty or taken, stalling as a whole.
// Reset (aresetn low, synchronous) clears the stage valid bits; data registers are not reset.
module euler_to_rotation_matrix_unit #(
    parameter int ANGLE_BITS    = e2r_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS     = e2r_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = e2r_pkg::CORDIC_STAGES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [e2r_pkg::IN_W-1:0]  s_roll_angle,
    input  logic signed [e2r_pkg::IN_W-1:0]  s_pitch_angle,
    input  logic signed [e2r_pkg::IN_W-1:0]  s_heading_angle,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [e2r_pkg::OUT_W-1:0] m_r0_c0,
    output logic signed [e2r_pkg::OUT_W-1:0] m_r0_c1,
    output logic signed [e2r_pkg::OUT_W-1:0] m_r0_c2,
    output logic signed [e2r_pkg::OUT_W-1:0] m_r1_c0,
    output logic signed [e2r_pkg::OUT_W-1:0] m_r1_c1,
    output logic signed [e2r_pkg::OUT_W-1:0] m_r1_c2,
    output logic signed [e2r_pkg::OUT_W-1:0] m_r2_c0,
    output logic signed [e2r_pkg::OUT_W-1:0] m_r2_c1,
    output logic signed [e2r_pkg::OUT_W-1:0] m_r2_c2
);

    localparam int NS  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int LAT = NS + 4;

    logic [LAT-1:0] vld_reg;
    logic           en;
    e2r_pkg::sc_t   rl_sc, pt_sc, hd_sc;
    logic signed [e2r_pkg::OUT_W-1:0] ent [0:8];

    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    e2r_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
        .aclk(aclk), .angle(s_roll_angle), .en(en), .sc(rl_sc));
    e2r_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
        .aclk(aclk), .angle(s_pitch_angle), .en(en), .sc(pt_sc));
    e2r_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_head (
        .aclk(aclk), .angle(s_heading_angle), .en(en), .sc(hd_sc));

    e2r_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .aclk(aclk), .en(en), .rl(rl_sc), .pt(pt_sc), .hd(hd_sc), .ent(ent));

    assign m_r0_c0 = ent[0];
    assign m_r0_c1 = ent[1];
    assign m_r0_c2 = ent[2];
    assign m_r1_c0 = ent[3];
    assign m_r1_c1 = ent[4];
    assign m_r1_c2 = ent[5];
    assign m_r2_c0 = ent[6];
    assign m_r2_c1 = ent[7];
    assign m_r2_c2 = ent[8];

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_r0_c0) && $stable(m_r2_c2))
        else $error("result changed while stalled");
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");
    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_r0_c1) <= $signed(16'sd1 <<< FRAC_BITS))
                 && ($signed(m_r0_c1) >= -$signed(16'sd1 <<< FRAC_BITS)))
        else $error("entry outside saturation range");

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the Euler-angle to rotation-matrix unit.
`timescale 1ns / 1ps

typedef struct {
    logic signed [15:0] e [9];
} dcm_t;

class dcm_scoreboard;
    dcm_t   pending[$];
    int     errors;

    static function void cordic_sc(input logic [15:0] ang, output longint c, output longint s);
        logic [31:0] a, d;
        logic [1:0]  q;
        longint      x, y, z, xs, ys;
        a = {ang, 16'd0};
        q = 2'((a + 32'h2000_0000) >> 30);
        d = a - ({30'd0, q} << 30);
        z = longint'($signed(d));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - longint'(e2r_pkg::atan_turn(i));
            end else begin
                x = x + ys; y = y - xs; z = z + longint'(e2r_pkg::atan_turn(i));
            end
        end
        case (q)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    static function logic signed [15:0] to_q14(input longint v60);
        longint v;
        v = (v60 + (longint'(1) <<< 45)) >>> 46;
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        return v[15:0];
    endfunction

    static function longint mul_q30(input longint a, input longint b);
        return (a * b + (longint'(1) <<< 29)) >>> 30;
    endfunction

    function void note_request(input logic [15:0] roll, input logic [15:0] pitch,
                               input logic [15:0] head);
        longint cr, sr, cp, sp, ch, sh;
        dcm_t   m;
        cordic_sc(roll, cr, sr);
        cordic_sc(pitch, cp, sp);
        cordic_sc(head, ch, sh);
        m.e[0] = to_q14(cp * ch);
        m.e[1] = to_q14(mul_q30(sp, sr) * ch - cr * sh);
        m.e[2] = to_q14(mul_q30(cr, sp) * ch + sh * sr);
        m.e[3] = to_q14(cp * sh);
        m.e[4] = to_q14(mul_q30(sr, sp) * sh + cr * ch);
        m.e[5] = to_q14(mul_q30(cr, sp) * sh - sr * ch);
        m.e[6] = to_q14(-(sp * (longint'(1) <<< 30)));
        m.e[7] = to_q14(sr * cp);
        m.e[8] = to_q14(cr * cp);
        pending.push_back(m);
    endfunction

    function void check_matrix(input dcm_t got);
        dcm_t want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result", $time);
            errors++;
            return;
        end
        want = pending.pop_front();
        for (int k = 0; k < 9; k++)
            if (got.e[k] !== want.e[k]) begin
                $display("%0t: entry r%0d_c%0d expected %0d actual %0d", $time,
                         k / 3, k % 3, want.e[k], got.e[k]);
                errors++;
            end
    endfunction
endclass

module testbench;

    localparam int LATENCY = 20;
    localparam int WATCHDOG = 2000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [e2r_pkg::IN_W-1:0] s_roll_angle = '0, s_pitch_angle = '0, s_heading_angle = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [e2r_pkg::OUT_W-1:0] m_r0_c0, m_r0_c1, m_r0_c2, m_r1_c0, m_r1_c1, m_r1_c2;
    logic signed [e2r_pkg::OUT_W-1:0] m_r2_c0, m_r2_c1, m_r2_c2;

    dcm_scoreboard sb = new();
    bit calm = 1'b0;
    int idle_cycles = 0;

    always #1 aclk = ~aclk;

    euler_to_rotation_matrix_unit u_top (.*);

    always @(posedge aclk) begin
        dcm_t got;
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_request(s_roll_angle, s_pitch_angle, s_heading_angle);
            if (m_valid && m_ready) begin
                got.e = '{m_r0_c0, m_r0_c1, m_r0_c2, m_r1_c0, m_r1_c1, m_r1_c2,
                          m_r2_c0, m_r2_c1, m_r2_c2};
                sb.check_matrix(got);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) ||
                (!s_valid && sb.pending.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("Simulation FAILED");
                $finish;
            end
            m_ready <= calm || ($urandom_range(99) >= 9);
        end
    end

    task automatic send_angles(input logic [15:0] r, input logic [15:0] p, input logic [15:0] h);
        while (!calm && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_roll_angle <= r;
        s_pitch_angle <= p;
        s_heading_angle <= h;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(5))
            0: return 16'(16'h4000 * $urandom_range(3) + $urandom_range(4) - 2);
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] corner [8];
        corner = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000,
                   16'hC000, 16'h0001, 16'hFFFF, 16'h2000};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < 8; i++)
            send_angles(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]);
        for (int i = 0; i < 8; i++)
            send_angles(corner[i], corner[i], corner[i]);
        send_angles(16'h4000, 16'h4000, 16'h4000);
        send_angles(16'hC000, 16'hC000, 16'hC000);
        stop_sending();
        // sender holds off until the pipeline has drained
        while (sb.pending.size() != 0) @(posedge aclk);
        for (int n = 0; n < 1530; n++) begin
            calm = (n >= 600 && n < 850);
            send_angles(pick_angle(), pick_angle(), pick_angle());
        end
        calm = 1'b0;
        stop_sending();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
